FILE: rtl/pwsd_pkg.sv
package pwsd_pkg;

	// Parameter defaults
	localparam int FRAC_BITS_DEF    = 16;
	localparam int ANGLE_BITS_DEF   = 16;
	localparam int CORDIC_ITERS_DEF = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_BOX_LENGTH    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DETECT_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_LENGTH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_X      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TARGET_Y      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY_MODE = 3'd5;

	localparam logic [1:0] BM_PERIODIC = 2'd1;

	// Register reset values
	localparam logic [30:0] BOX_LENGTH_RST    = 31'd65536000;
	localparam logic [21:0] DETECT_RADIUS_RST = 22'd65536;
	localparam logic [21:0] STEP_LENGTH_RST   = 22'd65536;

	// CORDIC gain 0.60725 in Q0.30
	localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

	// Datapath widths
	localparam int CNT_W  = 5;
	localparam int CORD_W = 26;
	localparam int MUL_W  = 28;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W  = 58;

	// Relative coordinates clip to +-2^25 raw units
	localparam logic signed [33:0] SEG_LIM = 34'sd33554432;

	typedef struct packed {
		logic [30:0]        box_length;
		logic [21:0]        detect_radius;
		logic [21:0]        step_length;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic [1:0]         boundary_mode;
	} cfg_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_INIT,
		OP_ROT,
		OP_POS_SUM,
		OP_POS_WRAP,
		OP_REL,
		OP_M_AX,
		OP_M_AY,
		OP_M_BX,
		OP_M_BY,
		OP_M_R,
		OP_M_OX,
		OP_M_OY,
		OP_M_NX,
		OP_M_NY,
		OP_N_SUM,
		OP_DEC,
		OP_DIV,
		OP_M_TX,
		OP_M_TY,
		OP_P_Y,
		OP_M_SX,
		OP_M_SY,
		OP_S_SUM
	} dp_op_t;

	typedef struct packed {
		logic             accept_place;
		logic             accept_step;
		dp_op_t           op;
		logic [CNT_W-1:0] cnt;
		logic             out_load;
		logic             is_step;
	} dp_cmd_t;

	// Arctangent of 2^-i as a fraction of a full turn, 32 bits
	function automatic logic [31:0] atan_turn(input logic [CNT_W-1:0] i);
		logic [31:0] v;
		unique case (i)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/pwsd_cfg.sv
module pwsd_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [pwsd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pwsd_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pwsd_pkg::cfg_t                      cfg
);

	pwsd_pkg::cfg_t cfg_q;

	// Register file, written without handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.box_length    <= pwsd_pkg::BOX_LENGTH_RST;
			cfg_q.detect_radius <= pwsd_pkg::DETECT_RADIUS_RST;
			cfg_q.step_length   <= pwsd_pkg::STEP_LENGTH_RST;
			cfg_q.target_x      <= '0;
			cfg_q.target_y      <= '0;
			cfg_q.boundary_mode <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pwsd_pkg::CFG_BOX_LENGTH:    cfg_q.box_length    <= cfg_data[30:0];
				pwsd_pkg::CFG_DETECT_RADIUS: cfg_q.detect_radius <= cfg_data[21:0];
				pwsd_pkg::CFG_STEP_LENGTH:   cfg_q.step_length   <= cfg_data[21:0];
				pwsd_pkg::CFG_TARGET_X:      cfg_q.target_x      <= cfg_data;
				pwsd_pkg::CFG_TARGET_Y:      cfg_q.target_y      <= cfg_data;
				pwsd_pkg::CFG_BOUNDARY_MODE: cfg_q.boundary_mode <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/pwsd_ctrl.sv
module pwsd_ctrl #(
	parameter int FRAC_BITS    = pwsd_pkg::FRAC_BITS_DEF,
	parameter int CORDIC_ITERS = pwsd_pkg::CORDIC_ITERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              opcode,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output pwsd_pkg::dp_cmd_t cmd
);

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FIN} state_t;

	state_t                     state_q;
	pwsd_pkg::dp_op_t           op_q;
	logic [pwsd_pkg::CNT_W-1:0] cnt_q;
	logic                       is_step_q;
	logic                       out_valid_q;
	logic                       out_load;
	logic                       in_xfer;

	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer  = in_valid && in_ready;
	// result register is free or being emptied this cycle
	assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= pwsd_pkg::OP_NONE;
			cnt_q       <= '0;
			is_step_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						is_step_q <= opcode;
						if (opcode) begin
							state_q <= ST_RUN;
							op_q    <= pwsd_pkg::OP_INIT;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_RUN: begin
					case (op_q)
						// one CORDIC rotation per cycle
						pwsd_pkg::OP_ROT: begin
							if (cnt_q == pwsd_pkg::CNT_W'(CORDIC_ITERS - 1)) begin
								cnt_q <= '0;
								op_q  <= pwsd_pkg::OP_POS_SUM;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						// one quotient bit per cycle
						pwsd_pkg::OP_DIV: begin
							if (cnt_q == pwsd_pkg::CNT_W'(FRAC_BITS - 1)) begin
								cnt_q <= '0;
								op_q  <= pwsd_pkg::OP_M_TX;
							end else begin
								cnt_q <= cnt_q + 1'b1;
							end
						end
						pwsd_pkg::OP_S_SUM: begin
							op_q    <= pwsd_pkg::OP_NONE;
							state_q <= ST_FIN;
						end
						default: begin
							op_q <= pwsd_pkg::dp_op_t'(op_q + 5'd1);
						end
					endcase
				end
				ST_FIN: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.accept_place = in_xfer && !opcode;
		cmd.accept_step  = in_xfer && opcode;
		cmd.op           = op_q;
		cmd.cnt          = cnt_q;
		cmd.out_load     = out_load;
		cmd.is_step      = is_step_q;
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/pwsd_dp.sv
module pwsd_dp #(
	parameter int FRAC_BITS  = pwsd_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_BITS = pwsd_pkg::ANGLE_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pwsd_pkg::cfg_t     cfg,
	input  pwsd_pkg::dp_cmd_t  cmd,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic signed [15:0] angle,
	output logic signed [31:0] walker_x,
	output logic signed [31:0] walker_y,
	output logic signed [15:0] heading,
	output logic               left_box,
	output logic               target_found
);

	localparam int MW = pwsd_pkg::MUL_W;
	localparam int AW = pwsd_pkg::ACC_W;
	localparam int CW = pwsd_pkg::CORD_W;

	typedef enum logic [1:0] {SEL_SEG, SEL_A, SEL_B} seg_sel_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sd2147483647) begin
			r = 32'sh7FFFFFFF;
		end else if (v < -34'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [MW-1:0] clip(input logic signed [33:0] v);
		logic signed [MW-1:0] r;
		if (v > pwsd_pkg::SEG_LIM) begin
			r = MW'(pwsd_pkg::SEG_LIM);
		end else if (v < -pwsd_pkg::SEG_LIM) begin
			r = MW'(-pwsd_pkg::SEG_LIM);
		end else begin
			r = MW'(v);
		end
		return r;
	endfunction

	// walker state
	logic signed [31:0]        pos_x_q, pos_y_q;
	logic [ANGLE_BITS-1:0]     hd_q;
	// CORDIC
	logic signed [CW-1:0]      cx_q, cy_q;
	logic signed [33:0]        zs_q;
	// stepped position
	logic signed [31:0]        nx_q, ny_q;
	logic                      left_q;
	// segment test
	logic signed [MW-1:0]      ax_q, ay_q, bx_q, by_q, opx_q, opy_q, px_q, py_q;
	logic signed [pwsd_pkg::PROD_W-1:0] prod_q;
	logic signed [AW-1:0]      sa_q, sb_q, r2_q, d_q, nsum_q, rem_q, dist_q;
	logic                      near_q, tfull_q;
	seg_sel_t                  sel_q;
	logic [FRAC_BITS:0]        t_q;
	// result register
	logic signed [31:0]        wx_q, wy_q;
	logic [15:0]               hdo_q;
	logic                      lb_q, tf_q;

	// CORDIC start vector
	logic [31:0]               z32, zf;
	logic                      flip;
	logic [51:0]               kprod;
	logic signed [CW-1:0]      x0s;
	always_comb begin
		z32   = 32'(hd_q) << (32 - ANGLE_BITS);
		flip  = z32[31] ^ z32[30];
		zf    = flip ? (z32 + 32'h80000000) : z32;
		kprod = 52'(cfg.step_length) * 52'(pwsd_pkg::CORDIC_GAIN);
		x0s   = CW'(kprod[51:30]);
	end

	// CORDIC micro-rotation
	logic signed [CW-1:0]      xs, ys;
	logic signed [33:0]        atan_s;
	always_comb begin
		xs     = cx_q >>> cmd.cnt;
		ys     = cy_q >>> cmd.cnt;
		atan_s = {2'b00, pwsd_pkg::atan_turn(cmd.cnt)};
	end

	// box test
	logic signed [33:0]        nx2, ny2, lbox;
	logic                      xlo, xhi, ylo, yhi, left_c;
	always_comb begin
		nx2    = {nx_q[31], nx_q, 1'b0};
		ny2    = {ny_q[31], ny_q, 1'b0};
		lbox   = {3'b000, cfg.box_length};
		xlo    = nx2 < -lbox;
		xhi    = nx2 >= lbox;
		ylo    = ny2 < -lbox;
		yhi    = ny2 >= lbox;
		left_c = xlo || xhi || ylo || yhi;
	end

	// shared multiplier operand select
	logic signed [MW-1:0]      mul_a, mul_b, t_eff, d_ext;
	always_comb begin
		t_eff = tfull_q ? MW'({1'b1, FRAC_BITS'(0)}) : MW'(t_q);
		d_ext = MW'(cfg.detect_radius);
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			pwsd_pkg::OP_M_AX: begin mul_a = ax_q;  mul_b = ax_q;  end
			pwsd_pkg::OP_M_AY: begin mul_a = ay_q;  mul_b = ay_q;  end
			pwsd_pkg::OP_M_BX: begin mul_a = bx_q;  mul_b = bx_q;  end
			pwsd_pkg::OP_M_BY: begin mul_a = by_q;  mul_b = by_q;  end
			pwsd_pkg::OP_M_R:  begin mul_a = d_ext; mul_b = d_ext; end
			pwsd_pkg::OP_M_OX: begin mul_a = opx_q; mul_b = opx_q; end
			pwsd_pkg::OP_M_OY: begin mul_a = opy_q; mul_b = opy_q; end
			pwsd_pkg::OP_M_NX: begin mul_a = ax_q;  mul_b = opx_q; end
			pwsd_pkg::OP_M_NY: begin mul_a = ay_q;  mul_b = opy_q; end
			pwsd_pkg::OP_M_TX: begin mul_a = opx_q; mul_b = t_eff; end
			pwsd_pkg::OP_M_TY: begin mul_a = opy_q; mul_b = t_eff; end
			pwsd_pkg::OP_M_SX: begin mul_a = px_q;  mul_b = px_q;  end
			pwsd_pkg::OP_M_SY: begin mul_a = py_q;  mul_b = py_q;  end
			default: ;
		endcase
	end

	logic signed [AW-1:0]      prod_ext, nv, rsh, dist_sel;
	always_comb begin
		prod_ext = AW'(prod_q);
		nv       = -nsum_q;
		rsh      = rem_q <<< 1;
		case (sel_q)
			SEL_A:   dist_sel = sa_q;
			SEL_B:   dist_sel = sb_q;
			default: dist_sel = dist_q;
		endcase
	end

	// walker state: loaded on place, heading turned on step, position on result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_x_q <= '0;
			pos_y_q <= '0;
			hd_q    <= '0;
		end else begin
			if (cmd.accept_place) begin
				pos_x_q <= start_x;
				pos_y_q <= start_y;
				hd_q    <= ANGLE_BITS'(angle);
			end else if (cmd.accept_step) begin
				hd_q <= hd_q + ANGLE_BITS'(angle);
			end else if (cmd.out_load && cmd.is_step) begin
				pos_x_q <= nx_q;
				pos_y_q <= ny_q;
			end
		end
	end

	// sequenced datapath work
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (cmd.op)
			pwsd_pkg::OP_INIT: begin
				cx_q <= flip ? -x0s : x0s;
				cy_q <= '0;
				zs_q <= 34'(signed'(zf));
			end
			pwsd_pkg::OP_ROT: begin
				if (!zs_q[33]) begin
					cx_q <= cx_q - ys;
					cy_q <= cy_q + xs;
					zs_q <= zs_q - atan_s;
				end else begin
					cx_q <= cx_q + ys;
					cy_q <= cy_q - xs;
					zs_q <= zs_q + atan_s;
				end
			end
			pwsd_pkg::OP_POS_SUM: begin
				nx_q <= sat32(34'(pos_x_q) + 34'(cx_q));
				ny_q <= sat32(34'(pos_y_q) + 34'(cy_q));
			end
			pwsd_pkg::OP_POS_WRAP: begin
				left_q <= left_c;
				if (left_c && cfg.boundary_mode == pwsd_pkg::BM_PERIODIC) begin
					if (xlo) begin
						nx_q <= 32'(34'(nx_q) + lbox);
					end else if (xhi) begin
						nx_q <= 32'(34'(nx_q) - lbox);
					end
					if (ylo) begin
						ny_q <= 32'(34'(ny_q) + lbox);
					end else if (yhi) begin
						ny_q <= 32'(34'(ny_q) - lbox);
					end
				end
			end
			pwsd_pkg::OP_REL: begin
				ax_q <= clip(34'(pos_x_q) - 34'(cfg.target_x));
				ay_q <= clip(34'(pos_y_q) - 34'(cfg.target_y));
				bx_q <= clip(34'(nx_q) - 34'(cfg.target_x));
				by_q <= clip(34'(ny_q) - 34'(cfg.target_y));
			end
			pwsd_pkg::OP_M_AX: begin
				opx_q <= bx_q - ax_q;
				opy_q <= by_q - ay_q;
			end
			pwsd_pkg::OP_M_AY: sa_q <= prod_ext;
			pwsd_pkg::OP_M_BX: sa_q <= sa_q + prod_ext;
			pwsd_pkg::OP_M_BY: sb_q <= prod_ext;
			pwsd_pkg::OP_M_R:  sb_q <= sb_q + prod_ext;
			pwsd_pkg::OP_M_OX: r2_q <= prod_ext;
			pwsd_pkg::OP_M_OY: begin
				d_q    <= prod_ext;
				near_q <= (sa_q < (r2_q <<< 2)) || (sb_q < (r2_q <<< 2));
			end
			pwsd_pkg::OP_M_NX: d_q    <= d_q + prod_ext;
			pwsd_pkg::OP_M_NY: nsum_q <= prod_ext;
			pwsd_pkg::OP_N_SUM: nsum_q <= nsum_q + prod_ext;
			// pick nearest point: start, end or interior projection
			pwsd_pkg::OP_DEC: begin
				if (d_q == '0 || nv < 0) begin
					sel_q <= SEL_A;
				end else if (nv > d_q) begin
					sel_q <= SEL_B;
				end else begin
					sel_q <= SEL_SEG;
				end
				tfull_q <= (nv == d_q);
				rem_q   <= nv;
				t_q     <= '0;
			end
			pwsd_pkg::OP_DIV: begin
				if (rsh >= d_q) begin
					rem_q <= rsh - d_q;
					t_q   <= {t_q[FRAC_BITS-1:0], 1'b1};
				end else begin
					rem_q <= rsh;
					t_q   <= {t_q[FRAC_BITS-1:0], 1'b0};
				end
			end
			pwsd_pkg::OP_M_TY: px_q <= ax_q + MW'(prod_q >>> FRAC_BITS);
			pwsd_pkg::OP_P_Y:  py_q <= ay_q + MW'(prod_q >>> FRAC_BITS);
			pwsd_pkg::OP_M_SY: dist_q <= prod_ext;
			pwsd_pkg::OP_S_SUM: dist_q <= dist_q + prod_ext;
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.is_step) begin
				wx_q <= nx_q;
				wy_q <= ny_q;
			end else begin
				wx_q <= pos_x_q;
				wy_q <= pos_y_q;
			end
			hdo_q <= 16'(hd_q);
			lb_q  <= cmd.is_step && left_q;
			tf_q  <= cmd.is_step && near_q && (dist_sel < r2_q);
		end
	end

	assign walker_x     = wx_q;
	assign walker_y     = wy_q;
	assign heading      = hdo_q;
	assign left_box     = lb_q;
	assign target_found = tf_q;

endmodule

FILE: rtl/persistent_walker_step_detect_core.sv
// Persistent 2D walker with target detection.
// Input channel (in_valid/in_ready) carries one item: opcode 0 places the
// walker at start_x/start_y with heading angle, opcode 1 turns by angle and
// moves step_length along the new heading. Output channel (out_valid/
// out_ready) returns the position, heading, left_box and target_found after
// each item. Registers must be written through cfg_wr_en/cfg_index/cfg_data
// only while the block is idle; the block itself does not enforce this.
// A place item goes straight to loading the result register. A step item
// runs CORDIC_ITERS CORDIC rotations, FRAC_BITS quotient bits of the
// projection divider and 21 single-multiplier and bookkeeping steps, then
// loads the result register.
// One item is in work at a time; the next is taken once the result sits in
// the output register, even if that result is not yet taken.
// A stalled receiver holds the result register; a finished item then waits
// for it to drain before its result is written.
// Reset clears position and heading to zero and loads register defaults.
module persistent_walker_step_detect_core #(
	parameter int FRAC_BITS    = pwsd_pkg::FRAC_BITS_DEF,
	parameter int ANGLE_BITS   = pwsd_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_ITERS = pwsd_pkg::CORDIC_ITERS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [pwsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pwsd_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            opcode,
	input  logic signed [31:0]              start_x,
	input  logic signed [31:0]              start_y,
	input  logic signed [15:0]              angle,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [31:0]              walker_x,
	output logic signed [31:0]              walker_y,
	output logic signed [15:0]              heading,
	output logic                            left_box,
	output logic                            target_found
);

	pwsd_pkg::cfg_t    cfg;
	pwsd_pkg::dp_cmd_t cmd;

	pwsd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pwsd_ctrl #(
		.FRAC_BITS    (FRAC_BITS),
		.CORDIC_ITERS (CORDIC_ITERS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.opcode    (opcode),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	pwsd_dp #(
		.FRAC_BITS  (FRAC_BITS),
		.ANGLE_BITS (ANGLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.cmd          (cmd),
		.start_x      (start_x),
		.start_y      (start_y),
		.angle        (angle),
		.walker_x     (walker_x),
		.walker_y     (walker_y),
		.heading      (heading),
		.left_box     (left_box),
		.target_found (target_found)
	);

endmodule

FILE: rtl/pwsd_checker.sv
module pwsd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               opcode,
	input logic signed [31:0] start_x,
	input logic               out_valid,
	input logic               out_ready,
	input logic signed [31:0] walker_x,
	input logic signed [15:0] heading,
	input logic               left_box,
	input logic               target_found
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(walker_x) && $stable(heading))
		else $error("result changed while stalled");

	// result leaves only by transfer
	a_out_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result dropped without transfer");

	// only one item in work
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second item taken while busy");

	// place result appears with the placed position, no flags
	a_place: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !opcode && !out_valid |->
		##2 (out_valid && walker_x == $past(start_x, 2) &&
		     !left_box && !target_found))
		else $error("place result wrong");

endmodule

bind persistent_walker_step_detect_core pwsd_checker u_pwsd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.opcode       (opcode),
	.start_x      (start_x),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.walker_x     (walker_x),
	.heading      (heading),
	.left_box     (left_box),
	.target_found (target_found)
);
